// ===== hw/rtl/rmf_pkg.sv =====
// Shared types and constants for the running median filter.
// No dependencies; every other file of the filter imports this package.
package rmf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int WINDOW_DEF = 100;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// What one sorted cell tells its upper neighbor: its entry after the
	// evicted sample is taken out, and whether that entry exists.
	typedef struct packed {
		sample_t u;
		logic    ok;
	} rmf_link_t;

endpackage

// ===== hw/rtl/rmf_sample_if.sv =====
// Input channel of the running median filter: valid/ready plus one sample.
// Depends on rmf_pkg.
interface rmf_sample_if import rmf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/rmf_median_if.sv =====
// Output channel of the running median filter: valid/ready plus one median.
// Depends on rmf_pkg.
interface rmf_median_if import rmf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t median;

	modport source (output valid, output median, input ready);
	modport sink   (input valid, input median, output ready);
endinterface

// ===== hw/rtl/rmf_age_line.sv =====
// Arrival-order delay line of the running median filter; yields the oldest item.
// Depends on rmf_pkg.
module rmf_age_line import rmf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift,
	input  sample_t x,
	output sample_t oldest
);

	sample_t line_q [WINDOW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				line_q[i] <= '0;
			end
		end else if (shift) begin
			line_q[0] <= x;
			for (int i = 1; i < WINDOW; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign oldest = line_q[WINDOW-1];

endmodule

// ===== hw/rtl/rmf_cell.sv =====
// One cell of the sorted chain: holds one window entry in ascending order.
// Depends on rmf_pkg.
module rmf_cell import rmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  sample_t   x,          // new item
	input  sample_t   e,          // evicted item
	input  sample_t   v_next,     // entry of the upper neighbor
	input  logic      next_ok,    // upper neighbor exists
	input  rmf_link_t link_prev,  // from the lower neighbor
	output rmf_link_t link,       // to the upper neighbor
	output sample_t   v,
	output sample_t   nxt
);

	sample_t v_q;
	logic    del_here_or_below;
	logic    keep_own;
	logic    take_prev;

	// Eviction sits at or below this cell when this entry is not below it.
	assign del_here_or_below = (v_q >= e);
	assign link.u  = del_here_or_below ? v_next : v_q;
	assign link.ok = next_ok;

	// Merge the new item into the chain with the evicted entry removed.
	assign keep_own  = link.ok && (link.u <= x);
	assign take_prev = link_prev.ok && (link_prev.u > x);

	always_comb begin
		if (keep_own) begin
			nxt = link.u;
		end else if (take_prev) begin
			nxt = link_prev.u;
		end else begin
			nxt = x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (load) begin
			v_q <= nxt;
		end
	end

	assign v = v_q;

endmodule

// ===== hw/rtl/running_median_filter.sv =====
// Running median filter over the last WINDOW items, one median per item.
// The median of an item is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; the sorted cell chain
// inserts and evicts together. A waiting median holds off the input until the same cycle it is taken.
// Reset: asynchronous, active low; all window entries read as zero afterward,
// so early medians are pulled toward zero.
module running_median_filter import rmf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rmf_sample_if.sink   samples,
	rmf_median_if.source medians
);

	localparam int MID = WINDOW / 2;

	// Chain signals, indexed by cell position (ascending value order).
	sample_t   cell_v   [WINDOW];
	sample_t   cell_nxt [WINDOW];
	rmf_link_t cell_link[WINDOW];

	logic    accept;
	sample_t evicted;
	sample_t median_q;
	logic    out_valid_q;

	// Take a new item whenever the output register is free or being drained.
	assign samples.ready = !out_valid_q || medians.ready;
	assign accept        = samples.valid && samples.ready;

	// Arrival order: the tail of the delay line is the item that drops out of
	// the window when the next one comes in.
	rmf_age_line #(
		.WINDOW(WINDOW)
	) u_age_line (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (accept),
		.x      (samples.sample),
		.oldest (evicted)
	);

	// Sorted chain: every cell drops the evicted entry and places the new item
	// by looking only at its two neighbors, so all cells move together.
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		sample_t   v_next;
		logic      next_ok;
		rmf_link_t link_prev;

		if (i < WINDOW - 1) begin : g_mid
			assign v_next  = cell_v[i+1];
			assign next_ok = 1'b1;
		end else begin : g_top
			assign v_next  = '0;
			assign next_ok = 1'b0;
		end

		if (i > 0) begin : g_lo
			assign link_prev = cell_link[i-1];
		end else begin : g_first
			assign link_prev = '0;
		end

		rmf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (accept),
			.x         (samples.sample),
			.e         (evicted),
			.v_next    (v_next),
			.next_ok   (next_ok),
			.link_prev (link_prev),
			.link      (cell_link[i]),
			.v         (cell_v[i]),
			.nxt       (cell_nxt[i])
		);
	end

	// Output register: capture the middle cell's new entry with the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (medians.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			median_q <= cell_nxt[MID];
		end
	end

	assign medians.valid  = out_valid_q;
	assign medians.median = median_q;

	// Every accepted item yields a median in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no median");

	// A pending median always matches the middle of the chain.
	a_median_matches_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (median_q == cell_v[MID]))
		else $error("median register disagrees with the sorted chain");

	// The chain stays sorted around the middle and at its ends.
	if (WINDOW > 1) begin : g_sorted_chk
		a_chain_sorted_mid: assert property (@(posedge clk) disable iff (!arst_n)
			cell_v[MID-1] <= cell_v[MID])
			else $error("sorted chain out of order at the median");

		a_chain_sorted_ends: assert property (@(posedge clk) disable iff (!arst_n)
			cell_v[0] <= cell_v[WINDOW-1])
			else $error("sorted chain ends out of order");
	end

endmodule

// ===== dv/rmf_median_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the running median filter: mirrors the sample window, predicts
// the median of every accepted item and compares it with the output channel.
// Depends on rmf_pkg, rmf_sample_if and rmf_median_if.
module rmf_median_checker import rmf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	rmf_sample_if samples,
	rmf_median_if medians,
	output int    mismatches,
	output int    outstanding
);

	sample_t     window_q [WINDOW];
	int unsigned oldest;
	sample_t     medians_due [$];
	int          medians_seen;

	// Overwrite the oldest entry, advance, and return the element at rank WINDOW/2.
	function automatic sample_t slide_window(input sample_t s);
		sample_t ranked [$];
		window_q[oldest] = s;
		oldest = (oldest + 1 >= WINDOW) ? 0 : oldest + 1;
		foreach (window_q[i]) ranked.push_back(window_q[i]);
		ranked.sort();
		return ranked[WINDOW / 2];
	endfunction

	task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
		$display("%0t: median %0d %s: got 0x%04h, want 0x%04h",
			$time, medians_seen, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (window_q[i]) window_q[i] = '0;
			oldest = 0;
			medians_due.delete();
			mismatches = 0;
			medians_seen = 0;
		end else begin
			// Retire first: a median leaving now belongs to an earlier item.
			if (medians.valid && medians.ready) begin
				if (medians_due.size() == 0) begin
					report_mismatch("with nothing expected", medians.median, '0);
				end else begin
					if (medians.median !== medians_due[0])
						report_mismatch("wrong value", medians.median, medians_due[0]);
					void'(medians_due.pop_front());
				end
				medians_seen++;
			end
			if (samples.valid && samples.ready)
				medians_due.push_back(slide_window(samples.sample));
		end
		outstanding = medians_due.size();
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Top of the running median filter testbench: clock, reset, sample stimulus,
// output back-pressure, watchdog and verdict.
// Depends on rmf_pkg, both channel interfaces, the filter and rmf_median_checker.
module tb;
	import rmf_pkg::*;

	localparam int WINDOW       = WINDOW_DEF;
	localparam int RANDOM_ITEMS = 1200;
	// Longest quiet stretch of a good run is the long receiver hold-off;
	// allow several times that before calling the run hung.
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 2000;
	// After the last median, keep watching to catch stray medians.
	localparam int DRAIN_CYCLES = 8;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   outstanding;
	bit   hold_req    = 1'b0;
	int   idle_cycles = 0;
	int   burst_left  = 0;

	rmf_sample_if samples_ch ();
	rmf_median_if medians_ch ();

	running_median_filter #(.WINDOW(WINDOW)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.medians (medians_ch)
	);

	// Watch both channels, predict and compare; report the miss count back here.
	rmf_median_checker #(.WINDOW(WINDOW)) median_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples_ch),
		.medians     (medians_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	// Count cycles in which no item moves on either channel; end a hung run.
	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (medians_ch.valid && medians_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offer one sample at the falling edge and hold it until the filter takes it.
	// Between bursts drop valid for a random gap, except while the receiver is
	// held off: then keep offering so the filter fills up and stalls its input.
	task automatic send_sample(input sample_t s);
		int gap;
		@(negedge clk);
		samples_ch.valid  <= 1'b1;
		samples_ch.sample <= s;
		do @(posedge clk); while (!samples_ch.ready);
		if (burst_left > 0) begin
			burst_left--;
		end else if (!hold_req) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			samples_ch.valid  <= 1'b0;
			samples_ch.sample <= sample_t'($urandom);
			repeat (gap - 1) @(negedge clk);
			// Mostly short bursts, now and then a long unbroken run.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 30);
		end
	endtask

	// Receiver: switch among stall patterns for random stretches, one of them
	// never stalling; honor the long hold-off once when the stimulus asks for it.
	initial begin : receiver
		int mode;
		int run;
		int phase;
		medians_ch.ready = 1'b0;
		phase = 0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			run  = $urandom_range(5, 80);
			repeat (run) begin
				@(negedge clk);
				if (hold_req) begin
					medians_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_req = 1'b0;
				end
				phase = (phase + 1) % 3;
				case (mode)
					0: medians_ch.ready <= 1'b1;
					1: medians_ch.ready <= 1'($urandom_range(0, 1));
					2: medians_ch.ready <= (phase != 0);
					default: medians_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		sample_t value;
		int      mode;
		int      seg;
		int      sent;
		int      lvl;
		int      base;
		samples_ch.valid  = 1'b0;
		samples_ch.sample = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: rails, a walking one through every bit, and repeated values.
		// The window still holds reset zeros here, so these medians stay at zero
		// until enough large samples have come in.
		send_sample('0);
		send_sample('1);
		for (int b = 0; b < SAMPLE_W; b++)
			send_sample(sample_t'(1) << b);
		repeat (3) send_sample(16'h1234);
		send_sample(16'hFFFE);
		send_sample(16'h0001);

		// Random: segments of one signal shape each.
		sent = 0;
		lvl  = 32768;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(20, 150);
			base = $urandom_range(0, 65532);
			for (int k = 0; k < seg && sent < RANDOM_ITEMS; k++) begin
				// Ask once for the long receiver hold-off, well into the run.
				if (sent == RANDOM_ITEMS / 4)
					hold_req = 1'b1;
				case (mode)
					0: value = sample_t'($urandom);
					1: begin
						// Drift with small noise and an occasional spike.
						lvl += int'($urandom_range(0, 64)) - 32;
						if (lvl < 0) lvl = 0;
						if (lvl > 65535) lvl = 65535;
						value = ($urandom_range(0, 15) == 0) ? sample_t'($urandom)
							: sample_t'(lvl);
					end
					2: value = sample_t'(base + $urandom_range(0, 3));
					default: begin
						case ($urandom_range(0, 4))
							0: value = '0;
							1: value = 16'h0001;
							2: value = 16'hFFFE;
							3: value = '1;
							default: value = sample_t'($urandom);
						endcase
					end
				endcase
				send_sample(value);
				sent++;
			end
		end

		// Drain: stop offering, wait for every median, then watch for extras.
		@(negedge clk);
		samples_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
